/* design/arqrt_pkg.sv */
// Package for the ARQ retransmit tracker: window size, codes, entry and
// cell control types shared by the cell chain, the head logic and the top.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package arqrt_pkg;
   localparam int WINDOW = 64;
   localparam int IDX_W  = $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);

   localparam logic [23:0] RTT_LIMIT_US = 24'd10000000;
   localparam logic [23:0] RTT_RESET_US = 24'd100000;

   localparam logic [1:0] MODE_SEND  = 2'd0;
   localparam logic [1:0] MODE_ACK   = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;
   localparam logic [1:0] MODE_CHECK = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   localparam logic [1:0] CSR_ALPHA   = 2'd0;
   localparam logic [1:0] CSR_RETRIES = 2'd1;
   localparam logic [1:0] CSR_MAXAGE  = 2'd2;

   typedef struct packed {
      logic        live;
      logic [31:0] sent_time;
      logic [31:0] last_time;
      logic [3:0]  retries;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic load;
      logic clear;
   } cell_ctl_type;
endpackage
`default_nettype wire

/* design/arqrt_cell.sv */
// One window entry of the tracker chain; loads a new send, shifts from its
// upper neighbor, or drops its live bit. Depends on arqrt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module arqrt_cell
   import arqrt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl,
   input  wire entry_type    load_entry,
   input  wire entry_type    next_entry,
   output entry_type         entry
);
   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.live <= 1'b0;
      end else if (ctl.clear) begin
         entry_ff.live <= 1'b0;
      end else if (ctl.load) begin
         entry_ff <= load_entry;
      end else if (ctl.shift) begin
         entry_ff <= next_entry;
      end
   end

   assign entry = entry_ff;
endmodule
`default_nettype wire

/* design/arqrt_head.sv */
// Head logic of the tracker chain: retransmit test and entry update for the
// entry at the bottom of the chain during a walk. Depends on arqrt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module arqrt_head
   import arqrt_pkg::*;
(
   input  wire entry_type          entry,
   input  wire logic [IDX_W-1:0]   idx,
   input  wire logic [IDX_W-1:0]   target,
   input  wire logic               is_ack,
   input  wire logic [31:0]        now_us,
   input  wire logic [3:0]         max_retries,
   input  wire logic [23:0]        ewma_rtt,
   output entry_type               out_entry,
   output logic                    due,
   output logic                    flag,
   output logic [31:0]             sent_age
);
   logic [31:0] last_age;

   always_comb begin
      last_age = now_us - entry.last_time;
      sent_age = now_us - entry.sent_time;
      if (entry.retries >= max_retries) begin
         due = 1'b0;
      end else if (entry.retries == 4'd0) begin
         due = 1'b1;
      end else begin
         due = !last_age[31] && ({1'b0, last_age[30:0]} > {8'd0, ewma_rtt});
      end
      flag      = is_ack && (idx < target) && entry.live && due;
      out_entry = entry;
      if (flag) begin
         out_entry.retries   = entry.retries + 4'd1;
         out_entry.last_time = now_us;
      end
      if (is_ack && (idx == target)) begin
         out_entry.live = 1'b0;
      end
   end
endmodule
`default_nettype wire

/* design/arq_retransmit_tracker_unit.sv */
// ARQ retransmit tracker top: chain of window cells with head logic and control.
// Send, recovery check, unknown ack or unknown query: result in the cycle after the
// transfer. Query: a full rotation of the 64-cell chain (walk state).
// Ack: full walk, EWMA multiply and sum, then shift out freed head entries.
// A new item is taken once the previous result has been transferred.
// Synchronous active-high reset; no clearing pass. Depends on arqrt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module arq_retransmit_tracker_unit
   import arqrt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // seq_nr[15:0], now_us[47:16]
   input  wire logic [1:0]  req_tuser,   // mode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // status[1:0], assigned_seq[17:2],
                                         // retx_count[24:18], retx_due[25],
                                         // keyframe_forced[26], ewma_rtt_us[50:27],
                                         // min_rtt_us[74:51], zero[79:75]
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [31:0] csr_wdata
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_WALK = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_SUM  = 3'd3;
   localparam logic [2:0] S_ADV  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       mode_ff, mode_in;
   logic [IDX_W-1:0] off_ff, off_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [31:0]      now_ff, now_in;
   logic [6:0]       retx_ff, retx_in;
   logic             due_ff, due_in;
   logic [23:0]      sample_ff, sample_in;
   logic             sample_ok_ff, sample_ok_in;
   logic [32:0]      prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic [15:0]      next_seq_ff, next_seq_in, oldest_ff, oldest_in;
   logic [23:0]      ewma_ff, ewma_in, minrtt_ff, minrtt_in;
   logic [15:0]      kf_cnt_ff, kf_cnt_in;
   logic [8:0]       alpha_ff;
   logic [3:0]       max_retries_ff;
   logic [31:0]      max_age_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [74:0]      rsp_data_ff, rsp_data_in;

   entry_type        cell_q [WINDOW];
   logic [WINDOW-1:0] live_vec;
   entry_type        tail_entry, load_entry, head_out;
   logic             shift_en, load_en, clear_en;
   logic             head_due, head_flag;
   logic [31:0]      head_age;

   logic             req_fire;
   logic [15:0]      count16, off16;
   logic [CNT_W-1:0] count;
   logic [31:0]      req_now, chk_age;
   logic [15:0]      req_seq;
   logic [8:0]       alpha_sel;
   logic [33:0]      ewma_sum;

   assign req_fire = req_tvalid && req_tready;
   assign req_seq  = req_tdata[15:0];
   assign req_now  = req_tdata[47:16];
   assign count16  = next_seq_ff - oldest_ff;
   assign count    = count16[CNT_W-1:0];
   assign off16    = req_seq - oldest_ff;
   assign chk_age  = req_now - cell_q[0].sent_time;
   assign alpha_sel = (alpha_ff > 9'd256) ? 9'd256 : alpha_ff;
   assign ewma_sum = {1'b0, prod_a_ff} + {1'b0, prod_b_ff} + 34'd128;

   always_comb begin
      load_entry.live      = 1'b1;
      load_entry.sent_time = req_now;
      load_entry.last_time = req_now;
      load_entry.retries   = 4'd0;
   end

   genvar g;
   generate
      for (g = 0; g < WINDOW; g++) begin : g_cell
         cell_ctl_type ctl;
         entry_type    nb;
         if (g == WINDOW - 1) begin : g_tail
            assign nb = tail_entry;
         end else begin : g_mid
            assign nb = cell_q[g+1];
         end
         assign ctl.shift = shift_en;
         assign ctl.load  = load_en && (count[IDX_W-1:0] == IDX_W'(g));
         assign ctl.clear = clear_en;
         assign live_vec[g] = cell_q[g].live;
         arqrt_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .load_entry (load_entry),
            .next_entry (nb),
            .entry      (cell_q[g])
         );
      end
   endgenerate

   arqrt_head u_head (
      .entry       (cell_q[0]),
      .idx         (idx_ff),
      .target      (off_ff),
      .is_ack      (mode_ff == MODE_ACK),
      .now_us      (now_ff),
      .max_retries (max_retries_ff),
      .ewma_rtt    (ewma_ff),
      .out_entry   (head_out),
      .due         (head_due),
      .flag        (head_flag),
      .sent_age    (head_age)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      off_in       = off_ff;
      idx_in       = idx_ff;
      now_in       = now_ff;
      retx_in      = retx_ff;
      due_in       = due_ff;
      sample_in    = sample_ff;
      sample_ok_in = sample_ok_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      next_seq_in  = next_seq_ff;
      oldest_in    = oldest_ff;
      ewma_in      = ewma_ff;
      minrtt_in    = minrtt_ff;
      kf_cnt_in    = kf_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      shift_en     = 1'b0;
      load_en      = 1'b0;
      clear_en     = 1'b0;
      tail_entry   = head_out;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mode_in = req_tuser;
               now_in  = req_now;
               off_in  = off16[IDX_W-1:0];
               idx_in  = '0;
               retx_in = 7'd0;
               due_in  = 1'b0;
               sample_ok_in = 1'b0;
               case (req_tuser)
                  MODE_SEND: begin
                     rsp_valid_in = 1'b1;
                     if (count == CNT_W'(WINDOW)) begin
                        rsp_data_in = {minrtt_ff, ewma_ff, 1'b0, 1'b0, 7'd0, 16'd0, ST_FULL};
                     end else begin
                        load_en     = 1'b1;
                        next_seq_in = next_seq_ff + 16'd1;
                        rsp_data_in = {minrtt_ff, ewma_ff, 1'b0, 1'b0, 7'd0,
                                       next_seq_ff, ST_OK};
                     end
                  end
                  MODE_CHECK: begin
                     rsp_valid_in = 1'b1;
                     if ((count != '0) && !chk_age[31] &&
                         ({1'b0, chk_age[30:0]} > max_age_ff)) begin
                        clear_en    = 1'b1;
                        oldest_in   = next_seq_ff;
                        kf_cnt_in   = kf_cnt_ff + 16'd1;
                        rsp_data_in = {minrtt_ff, ewma_ff, 1'b1, 1'b0, 7'd0, 16'd0, ST_OK};
                     end else begin
                        rsp_data_in = {minrtt_ff, ewma_ff, 1'b0, 1'b0, 7'd0, 16'd0, ST_OK};
                     end
                  end
                  default: begin
                     if ((off16 >= count16) || !live_vec[off16[IDX_W-1:0]]) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = {minrtt_ff, ewma_ff, 1'b0, 1'b0, 7'd0, 16'd0,
                                        ST_UNKNOWN};
                     end else begin
                        state_in = S_WALK;
                     end
                  end
               endcase
            end
         end
         S_WALK: begin
            shift_en = 1'b1;
            idx_in   = idx_ff + 1'b1;
            if (head_flag) begin
               retx_in = retx_ff + 7'd1;
            end
            if (idx_ff == off_ff) begin
               due_in       = head_due;
               sample_in    = head_age[23:0];
               sample_ok_in = !head_age[31] && (head_age != 32'd0) &&
                              (head_age < {8'd0, RTT_LIMIT_US});
            end
            if (idx_ff == IDX_W'(WINDOW - 1)) begin
               if (mode_ff == MODE_QUERY) begin
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {minrtt_ff, ewma_ff, 1'b0, due_in, 7'd0, 16'd0, ST_OK};
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            prod_a_in = 33'(alpha_sel) * 33'(sample_ff);
            prod_b_in = 33'(9'd256 - alpha_sel) * 33'(ewma_ff);
            state_in  = S_SUM;
         end
         S_SUM: begin
            if (sample_ok_ff) begin
               ewma_in = ewma_sum[31:8];
               if (sample_ff < minrtt_ff) begin
                  minrtt_in = sample_ff;
               end
            end
            state_in = S_ADV;
         end
         S_ADV: begin
            tail_entry      = head_out;
            tail_entry.live = 1'b0;
            if ((count != '0) && !cell_q[0].live) begin
               shift_en  = 1'b1;
               oldest_in = oldest_ff + 16'd1;
            end else begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {minrtt_ff, ewma_ff, 1'b0, 1'b0, retx_ff, 16'd0, ST_OK};
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         next_seq_ff    <= 16'd0;
         oldest_ff      <= 16'd0;
         ewma_ff        <= RTT_RESET_US;
         minrtt_ff      <= RTT_LIMIT_US;
         kf_cnt_ff      <= 16'd0;
         rsp_valid_ff   <= 1'b0;
         alpha_ff       <= 9'd32;
         max_retries_ff <= 4'd3;
         max_age_ff     <= 32'd1000000;
      end else begin
         state_ff     <= state_in;
         next_seq_ff  <= next_seq_in;
         oldest_ff    <= oldest_in;
         ewma_ff      <= ewma_in;
         minrtt_ff    <= minrtt_in;
         kf_cnt_ff    <= kf_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_ALPHA:   alpha_ff       <= csr_wdata[8:0];
               CSR_RETRIES: max_retries_ff <= csr_wdata[3:0];
               CSR_MAXAGE:  max_age_ff     <= csr_wdata;
               default:     ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      off_ff       <= off_in;
      idx_ff       <= idx_in;
      now_ff       <= now_in;
      retx_ff      <= retx_in;
      due_ff       <= due_in;
      sample_ff    <= sample_in;
      sample_ok_ff <= sample_ok_in;
      prod_a_ff    <= prod_a_in;
      prod_b_ff    <= prod_b_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};
endmodule
`default_nettype wire

/* design/arqrt_checker.sv */
// Port-level checks for the ARQ retransmit tracker top, bound to it below.
// Depends on arqrt_pkg and arq_retransmit_tracker_unit.
`timescale 1ns / 1ps
`default_nettype none
module arqrt_checker
   import arqrt_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [79:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid)
      else $error("item taken while a result is pending");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("bad status code");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ST_OK |-> rsp_tdata[26:2] == 25'd0)
      else $error("fields set on a refused item");

   a_send_quick: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == MODE_SEND |=> rsp_tvalid)
      else $error("send result late");
endmodule

bind arq_retransmit_tracker_unit arqrt_checker u_arqrt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
